### design/isgl_pkg.sv
// isgl_pkg: shared widths, codes, transaction structs and the sigmoid table
// for the ising glauber spin update block; depends on nothing
package isgl_pkg;

    localparam int MAX_SPINS   = 64;
    localparam int IDX_W       = $clog2(MAX_SPINS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COUP_W      = 16;
    localparam int COUP_DEPTH  = MAX_SPINS * MAX_SPINS;
    localparam int COUP_AW     = 2 * IDX_W;
    localparam int FIELD_W     = 24;
    localparam int ACC_W       = FIELD_W + 2;
    localparam int CERT_W      = 7;
    localparam int PROB_W      = 16;
    localparam int RND_W       = 16;
    localparam int TEMP_W      = 16;
    localparam int ENERGY_W    = 32;
    localparam int X_W         = FIELD_W + TEMP_W + 2;
    localparam int OFF_W       = X_W + 1;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int FIELD_MAX = 8388607;
    localparam int FIELD_MIN = -8388608;
    localparam logic signed [ACC_W-1:0] ACC_FIELD_MAX = ACC_W'(FIELD_MAX);
    localparam logic signed [ACC_W-1:0] ACC_FIELD_MIN = ACC_W'(FIELD_MIN);
    localparam logic [CERT_W-1:0] CERT_RESET = CERT_W'(50);
    localparam logic [CERT_W-1:0] CERT_MAX   = CERT_W'(100);
    localparam logic [CNT_W-1:0]  SPIN_LIMIT = CNT_W'(MAX_SPINS);

    localparam logic signed [1:0] SPIN_POS  = 2'sb01;
    localparam logic signed [1:0] SPIN_NEG  = 2'sb11;
    localparam logic signed [1:0] SPIN_ZERO = 2'sb00;
    localparam logic signed [1:0] SPIN_LOW  = 2'sb10;

    typedef enum logic [2:0]
    {
        CMD_SET_SPIN     = 3'd0,
        CMD_SET_COUPLING = 3'd1,
        CMD_ADD_EVIDENCE = 3'd2,
        CMD_UPDATE       = 3'd3,
        CMD_READ_ENERGY  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ACTIVE_COUNT = 2'd0,
        REG_INV_TEMP     = 2'd1
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_UROW,
        S_UMUL,
        S_UPROB,
        S_UDONE,
        S_EHEAD,
        S_EHDAT,
        S_EROW,
        S_EDONE
    } back_state_t;

    typedef struct packed
    {
        logic [2:0]              cmd;
        logic [IDX_W-1:0]        a;
        logic [IDX_W-1:0]        b;
        logic signed [COUP_W-1:0] value;
        logic signed [1:0]       spin;
        logic [RND_W-1:0]        rnd;
        logic                    reject;
        logic                    a_ok;
        logic [CNT_W-1:0]        n;
    } op_t;

    typedef struct packed
    {
        logic                      status;
        logic signed [1:0]         new_spin;
        logic signed [FIELD_W-1:0] local_field;
        logic [PROB_W-1:0]         prob_up;
        logic signed [ENERGY_W-1:0] energy;
        logic [CERT_W-1:0]         certainty;
    } res_t;

    typedef struct packed
    {
        logic clearing;
    } back_stat_t;

    typedef logic [PROB_W-1:0] sig_tab_t [SIG_ENTRIES];

    function automatic logic signed [FIELD_W-1:0] sat_field(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > ACC_FIELD_MAX)
            r = ACC_FIELD_MAX;
        else if (v < ACC_FIELD_MIN)
            r = ACC_FIELD_MIN;
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) in q31 for a in q16
    function automatic logic [63:0] exp_neg_q31(logic [63:0] a);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] t;
        y    = a << 11;
        term = 64'h8000_0000;
        sum  = 64'h8000_0000;
        for (int n = 1; n <= 12; n++)
        begin
            t = (term * y) >> 31;
            case (n)
                1:       term = t;
                2:       term = t / 2;
                3:       term = t / 3;
                4:       term = t / 4;
                5:       term = t / 5;
                6:       term = t / 6;
                7:       term = t / 7;
                8:       term = t / 8;
                9:       term = t / 9;
                10:      term = t / 10;
                11:      term = t / 11;
                12:      term = t / 12;
                default: term = t;
            endcase
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int n = 0; n < 4; n++)
            sum = (sum * sum) >> 31;
        return sum;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t    tab;
        longint      c;
        logic [63:0] mag;
        logic [63:0] d;
        logic [63:0] p;
        for (int k = 0; k < SIG_ENTRIES; k++)
        begin
            c   = ((2 * longint'(k) + 1) * 524288) / SIG_ENTRIES - 524288;
            mag = 64'((c < 0) ? -c : c);
            d   = (64'd1 << 31) + exp_neg_q31(mag);
            p   = udiv64((64'd1 << 47) + (d >> 1), d);
            if (c < 0)
                p = 64'd65536 - p;
            if (p > 64'd65535)
                p = 64'd65535;
            tab[k] = p[PROB_W-1:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

### design/ising_glauber_spin_update.sv
// ising_glauber_spin_update: top level, front intake, op queue, back sequencer
// and result queue; depends on isgl_pkg, isgl_front, isgl_fifo, isgl_back
//
//   channel   handshake              payload
//   command   push / full            command index_a index_b value spin_value random_value
//   config    cfg_valid / cfg_ready  cfg_index cfg_data
//   result    empty / pop            status new_spin local_field prob_up energy certainty
//
// set spin, set coupling, add evidence and rejected commands finish in the exec state
// update walks one coupling row through the memory read port
// read energy walks the upper triangle
// after reset a clearing pass zeroes every coupling memory entry, full stays high
// two-entry queues on each side let intake and results stall independently
module ising_glauber_spin_update
    import isgl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [2:0]                command,
    input  logic [IDX_W-1:0]          index_a,
    input  logic [IDX_W-1:0]          index_b,
    input  logic signed [COUP_W-1:0]  value,
    input  logic signed [1:0]         spin_value,
    input  logic [RND_W-1:0]          random_value,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      empty,
    input  logic                      pop,
    output logic                      status,
    output logic signed [1:0]         new_spin,
    output logic signed [FIELD_W-1:0] local_field,
    output logic [PROB_W-1:0]         prob_up,
    output logic signed [ENERGY_W-1:0] energy,
    output logic [CERT_W-1:0]         certainty
);

    back_stat_t        back_stat;
    logic              op_full;
    logic              op_push;
    op_t               op_in;
    op_t               op_out;
    logic              op_empty;
    logic              op_pop;
    logic [TEMP_W-1:0] inv_temperature;
    logic              res_push;
    logic              res_full;
    res_t              res_in;
    res_t              res_out;

    isgl_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .index_a         (index_a),
        .index_b         (index_b),
        .value           (value),
        .spin_value      (spin_value),
        .random_value    (random_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .back_stat       (back_stat),
        .op_full         (op_full),
        .op_push         (op_push),
        .op              (op_in),
        .inv_temperature (inv_temperature)
    );

    isgl_fifo #(.T(op_t)) u_op_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .full  (op_full),
        .pop   (op_pop),
        .dout  (op_out),
        .empty (op_empty)
    );

    isgl_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .inv_temperature (inv_temperature),
        .op_empty        (op_empty),
        .op              (op_out),
        .op_pop          (op_pop),
        .res_full        (res_full),
        .res_push        (res_push),
        .res             (res_in),
        .back_stat       (back_stat)
    );

    isgl_fifo #(.T(res_t)) u_res_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign status      = res_out.status;
    assign new_spin    = res_out.new_spin;
    assign local_field = res_out.local_field;
    assign prob_up     = res_out.prob_up;
    assign energy      = res_out.energy;
    assign certainty   = res_out.certainty;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> full)
        else $error("intake open during clearing pass");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (new_spin == SPIN_ZERO && certainty == '0
                                && energy == '0 && local_field == '0 && prob_up == '0))
        else $error("rejected transaction carries data");

    a_cert_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (certainty <= CERT_MAX))
        else $error("certainty above maximum");
`endif

endmodule

### design/isgl_fifo.sv
// isgl_fifo: short first-in first-out queue of transactions of any packed type
// depends on isgl_pkg for depth and pointer widths
module isgl_fifo
    import isgl_pkg::*;
#(
    parameter type T = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    T                  ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= din;
    end

endmodule

### design/isgl_front.sv
// isgl_front: configuration registers, command intake and range classification
// depends on isgl_pkg; feeds the op queue in front of isgl_back
module isgl_front
    import isgl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             command,
    input  logic [IDX_W-1:0]       index_a,
    input  logic [IDX_W-1:0]       index_b,
    input  logic signed [COUP_W-1:0] value,
    input  logic signed [1:0]      spin_value,
    input  logic [RND_W-1:0]       random_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  back_stat_t             back_stat,
    input  logic                   op_full,
    output logic                   op_push,
    output op_t                    op,
    output logic [TEMP_W-1:0]      inv_temperature
);

    logic [CNT_W-1:0]  active_reg;
    logic [TEMP_W-1:0] inv_temp_reg;
    logic [CNT_W-1:0]  n;
    logic              a_ok;
    logic              b_ok;

    assign cfg_ready       = 1'b1;
    assign inv_temperature = inv_temp_reg;
    assign full            = op_full || back_stat.clearing;
    assign op_push         = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= SPIN_LIMIT;
            inv_temp_reg <= TEMP_W'(256);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ACTIVE_COUNT)
                active_reg <= cfg_data[CNT_W-1:0];
            else if (cfg_index == REG_INV_TEMP)
                inv_temp_reg <= cfg_data[TEMP_W-1:0];
        end
    end

    always_comb
    begin
        n    = (active_reg > SPIN_LIMIT) ? SPIN_LIMIT : active_reg;
        a_ok = {1'b0, index_a} < n;
        b_ok = {1'b0, index_b} < n;
        op.cmd    = command;
        op.a      = index_a;
        op.b      = index_b;
        op.value  = value;
        op.spin   = (spin_value == SPIN_LOW) ? SPIN_NEG : spin_value;
        op.rnd    = random_value;
        op.a_ok   = a_ok;
        op.n      = n;
        op.reject = (command <= CMD_UPDATE)
                    && (!a_ok || (command == CMD_SET_COUPLING && !b_ok));
    end

endmodule

### design/isgl_back.sv
// isgl_back: sequencer that executes classified commands against the spin,
// field, certainty and coupling memories; depends on isgl_pkg
module isgl_back
    import isgl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TEMP_W-1:0] inv_temperature,
    input  logic              op_empty,
    input  op_t               op,
    output logic              op_pop,
    input  logic              res_full,
    output logic              res_push,
    output res_t              res,
    output back_stat_t        back_stat
);

    back_state_t state_reg;
    back_state_t state_next;
    op_t         cur_reg;
    op_t         cur_next;

    logic [COUP_AW-1:0]        clr_reg;
    logic [COUP_AW-1:0]        clr_next;
    logic [CNT_W-1:0]          i_reg;
    logic [CNT_W-1:0]          i_next;
    logic [CNT_W-1:0]          j_reg;
    logic [CNT_W-1:0]          j_next;
    logic                      p_vld_reg;
    logic                      p_vld_next;
    logic                      p_use_reg;
    logic                      p_use_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ENERGY_W-1:0] eacc_reg;
    logic signed [ENERGY_W-1:0] eacc_next;
    logic signed [1:0]         spin_a_reg;
    logic signed [1:0]         spin_a_next;
    logic [CERT_W-1:0]         cert_a_reg;
    logic [CERT_W-1:0]         cert_a_next;
    logic signed [1:0]         s_i_reg;
    logic signed [1:0]         s_i_next;
    logic signed [FIELD_W-1:0] h_reg;
    logic signed [FIELD_W-1:0] h_next;
    logic signed [X_W-1:0]     x_reg;
    logic signed [X_W-1:0]     x_next;
    logic [PROB_W-1:0]         prob_reg;
    logic [PROB_W-1:0]         prob_next;

    logic signed [COUP_W-1:0]  coup_mem [COUP_DEPTH];
    logic signed [COUP_W-1:0]  coup_rd_reg;
    logic                      coup_we;
    logic [COUP_AW-1:0]        coup_wa;
    logic signed [COUP_W-1:0]  coup_wd;
    logic [COUP_AW-1:0]        coup_ra;

    logic signed [1:0]         spin_mem [MAX_SPINS];
    logic [CERT_W-1:0]         cert_mem [MAX_SPINS];
    logic [MAX_SPINS-1:0]      spin_vld_reg;
    logic signed [1:0]         spin_rd_reg;
    logic                      spin_rv_reg;
    logic [CERT_W-1:0]         cert_rd_reg;
    logic                      cert_rv_reg;
    logic                      spin_we;
    logic signed [1:0]         spin_wd;
    logic [CERT_W-1:0]         cert_wd;
    logic [IDX_W-1:0]          spin_ra;

    logic signed [FIELD_W-1:0] field_mem [MAX_SPINS];
    logic [MAX_SPINS-1:0]      fld_vld_reg;
    logic signed [FIELD_W-1:0] field_rd_reg;
    logic                      field_rv_reg;
    logic                      field_we;
    logic signed [FIELD_W-1:0] field_wd;
    logic [IDX_W-1:0]          field_ra;

    logic signed [1:0]         spin_val;
    logic [CERT_W-1:0]         cert_val;
    logic signed [FIELD_W-1:0] field_val;
    logic                      issue;
    logic signed [ACC_W-1:0]   ev_sum;
    logic signed [X_W-2:0]     prod;
    logic signed [OFF_W-1:0]   off;
    logic [SIG_BITS-1:0]       k;
    logic signed [1:0]         draw;
    logic                      show_a;

    function automatic logic [COUP_AW-1:0] caddr(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
        return (x < y) ? {x, y} : {y, x};
    endfunction

    assign spin_val  = spin_rv_reg ? spin_rd_reg : SPIN_ZERO;
    assign cert_val  = cert_rv_reg ? cert_rd_reg : CERT_RESET;
    assign field_val = field_rv_reg ? field_rd_reg : '0;
    assign back_stat.clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        clr_next    = clr_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_vld_next  = 1'b0;
        p_use_next  = 1'b0;
        acc_next    = acc_reg;
        eacc_next   = eacc_reg;
        spin_a_next = spin_a_reg;
        cert_a_next = cert_a_reg;
        s_i_next    = s_i_reg;
        h_next      = h_reg;
        x_next      = x_reg;
        prob_next   = prob_reg;
        op_pop      = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        coup_we     = 1'b0;
        coup_wa     = caddr(cur_reg.a, cur_reg.b);
        coup_wd     = cur_reg.value;
        coup_ra     = caddr(cur_reg.a, j_reg[IDX_W-1:0]);
        spin_we     = 1'b0;
        spin_wd     = cur_reg.spin;
        cert_wd     = CERT_RESET;
        spin_ra     = cur_reg.a;
        field_we    = 1'b0;
        field_wd    = '0;
        field_ra    = cur_reg.a;
        issue       = 1'b0;
        ev_sum      = ACC_W'(field_val) + ACC_W'(cur_reg.value);
        prod        = '0;
        off         = '0;
        k           = '0;
        draw        = SPIN_ZERO;
        show_a      = !cur_reg.reject && cur_reg.a_ok;

        case (state_reg)
            S_CLEAR:
            begin
                coup_we  = 1'b1;
                coup_wa  = clr_reg;
                coup_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == COUP_AW'(COUP_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!op_empty && !res_full)
                begin
                    op_pop     = 1'b1;
                    cur_next   = op;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                spin_a_next     = spin_val;
                cert_a_next     = cert_val;
                res.status      = cur_reg.reject;
                res.new_spin    = show_a ? spin_val : SPIN_ZERO;
                res.certainty   = show_a ? cert_val : '0;
                state_next      = S_IDLE;
                if (cur_reg.reject)
                    res_push = 1'b1;
                else
                begin
                    case (cur_reg.cmd)
                        CMD_SET_SPIN:
                        begin
                            spin_we       = 1'b1;
                            res.new_spin  = cur_reg.spin;
                            res.certainty = CERT_RESET;
                            res_push      = 1'b1;
                        end
                        CMD_SET_COUPLING:
                        begin
                            coup_we  = 1'b1;
                            res_push = 1'b1;
                        end
                        CMD_ADD_EVIDENCE:
                        begin
                            field_we = 1'b1;
                            field_wd = sat_field(ev_sum);
                            res_push = 1'b1;
                        end
                        CMD_UPDATE:
                        begin
                            acc_next   = ACC_W'(field_val);
                            j_next     = '0;
                            state_next = S_UROW;
                        end
                        CMD_READ_ENERGY:
                        begin
                            eacc_next  = '0;
                            i_next     = '0;
                            state_next = (cur_reg.n == '0) ? S_EDONE : S_EHEAD;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_UROW:
            begin
                issue      = (j_reg < cur_reg.n);
                spin_ra    = j_reg[IDX_W-1:0];
                p_vld_next = issue;
                p_use_next = issue && (j_reg[IDX_W-1:0] != cur_reg.a);
                if (p_vld_reg && p_use_reg)
                begin
                    if (spin_val == SPIN_POS)
                        acc_next = acc_reg + ACC_W'(coup_rd_reg);
                    else if (spin_val == SPIN_NEG)
                        acc_next = acc_reg - ACC_W'(coup_rd_reg);
                end
                if (issue)
                    j_next = j_reg + 1'b1;
                else
                    state_next = S_UMUL;
            end
            S_UMUL:
            begin
                h_next     = sat_field(acc_reg);
                prod       = (X_W-1)'(h_next) * (X_W-1)'($signed({1'b0, inv_temperature}));
                x_next     = {prod, 1'b0};
                state_next = S_UPROB;
            end
            S_UPROB:
            begin
                off = OFF_W'(x_reg) + OFF_W'(524288);
                if (off < 0)
                    k = '0;
                else if (off >= OFF_W'(1048576))
                    k = SIG_BITS'(SIG_ENTRIES - 1);
                else
                    k = off[19 -: SIG_BITS];
                prob_next  = SIG_TAB[k];
                state_next = S_UDONE;
            end
            S_UDONE:
            begin
                if (spin_a_reg == SPIN_NEG)
                    draw = ({1'b0, cur_reg.rnd} < (17'd65536 - {1'b0, prob_reg}))
                           ? SPIN_NEG : SPIN_POS;
                else
                    draw = (cur_reg.rnd < prob_reg) ? SPIN_POS : SPIN_NEG;
                spin_we         = 1'b1;
                spin_wd         = draw;
                cert_wd         = (cert_a_reg < CERT_MAX) ? cert_a_reg + 1'b1 : cert_a_reg;
                res.new_spin    = draw;
                res.certainty   = cert_wd;
                res.local_field = h_reg;
                res.prob_up     = prob_reg;
                res_push        = 1'b1;
                state_next      = S_IDLE;
            end
            S_EHEAD:
            begin
                spin_ra    = i_reg[IDX_W-1:0];
                field_ra   = i_reg[IDX_W-1:0];
                state_next = S_EHDAT;
            end
            S_EHDAT:
            begin
                s_i_next = spin_val;
                if (spin_val == SPIN_POS)
                    eacc_next = eacc_reg - ENERGY_W'(field_val);
                else if (spin_val == SPIN_NEG)
                    eacc_next = eacc_reg + ENERGY_W'(field_val);
                j_next     = i_reg + 1'b1;
                state_next = S_EROW;
            end
            S_EROW:
            begin
                issue      = (j_reg < cur_reg.n);
                spin_ra    = j_reg[IDX_W-1:0];
                coup_ra    = {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]};
                p_vld_next = issue;
                if (p_vld_reg && s_i_reg != SPIN_ZERO && spin_val != SPIN_ZERO)
                begin
                    if (s_i_reg == spin_val)
                        eacc_next = eacc_reg - ENERGY_W'(coup_rd_reg);
                    else
                        eacc_next = eacc_reg + ENERGY_W'(coup_rd_reg);
                end
                if (issue)
                    j_next = j_reg + 1'b1;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ((i_reg + 1'b1) < cur_reg.n) ? S_EHEAD : S_EDONE;
                end
            end
            S_EDONE:
            begin
                res.new_spin  = cur_reg.a_ok ? spin_a_reg : SPIN_ZERO;
                res.certainty = cur_reg.a_ok ? cert_a_reg : '0;
                res.energy    = eacc_reg;
                res_push      = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            p_vld_reg    <= 1'b0;
            p_use_reg    <= 1'b0;
            spin_vld_reg <= '0;
            fld_vld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            p_vld_reg <= p_vld_next;
            p_use_reg <= p_use_next;
            if (spin_we)
                spin_vld_reg[cur_reg.a] <= 1'b1;
            if (field_we)
                fld_vld_reg[cur_reg.a] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        eacc_reg   <= eacc_next;
        spin_a_reg <= spin_a_next;
        cert_a_reg <= cert_a_next;
        s_i_reg    <= s_i_next;
        h_reg      <= h_next;
        x_reg      <= x_next;
        prob_reg   <= prob_next;
    end

    always_ff @(posedge clk)
    begin
        if (coup_we)
            coup_mem[coup_wa] <= coup_wd;
        coup_rd_reg <= coup_mem[coup_ra];
    end

    always_ff @(posedge clk)
    begin
        if (spin_we)
        begin
            spin_mem[cur_reg.a] <= spin_wd;
            cert_mem[cur_reg.a] <= cert_wd;
        end
        spin_rd_reg <= spin_mem[spin_ra];
        spin_rv_reg <= spin_vld_reg[spin_ra];
        cert_rd_reg <= cert_mem[cur_reg.a];
        cert_rv_reg <= spin_vld_reg[cur_reg.a];
    end

    always_ff @(posedge clk)
    begin
        if (field_we)
            field_mem[cur_reg.a] <= field_wd;
        field_rd_reg <= field_mem[field_ra];
        field_rv_reg <= fld_vld_reg[field_ra];
    end

endmodule

### sim/tb_ising_glauber_spin_update.sv
// tb_ising_glauber_spin_update: self-checking testbench for the ising glauber spin update block
// keeps its own copy of spins, couplings, fields and certainties and predicts every result
// depends on isgl_pkg and ising_glauber_spin_update
module tb_ising_glauber_spin_update;
    import isgl_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         IDLE_PCT        = 17;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [2:0]                 command;
    logic [IDX_W-1:0]           index_a;
    logic [IDX_W-1:0]           index_b;
    logic signed [COUP_W-1:0]   value;
    logic signed [1:0]          spin_value;
    logic [RND_W-1:0]           random_value;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       empty;
    logic                       pop;
    logic                       status;
    logic signed [1:0]          new_spin;
    logic signed [FIELD_W-1:0]  local_field;
    logic [PROB_W-1:0]          prob_up;
    logic signed [ENERGY_W-1:0] energy;
    logic [CERT_W-1:0]          certainty;

    // shadow state of the block
    logic signed [1:0]         spin_shadow [MAX_SPINS];
    logic signed [COUP_W-1:0]  coup_shadow [COUP_DEPTH];
    logic signed [FIELD_W-1:0] field_shadow [MAX_SPINS];
    logic [CERT_W-1:0]         cert_shadow [MAX_SPINS];
    logic [PROB_W-1:0]         prob_table [SIG_ENTRIES];
    int                        active_setting;
    int                        temp_setting;

    res_t results_due [$];
    int   error_count;
    bit   steady;
    int   hold_off;

    ising_glauber_spin_update dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] exp_neg_fixed(logic [63:0] a);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] acc;
        y    = a << 11;
        term = 64'd1 << 31;
        acc  = 64'd1 << 31;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * y) >> 31) / 64'(n);
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        for (int n = 0; n < 4; n++)
            acc = (acc * acc) >> 31;
        return acc;
    endfunction

    function automatic void fill_prob_table();
        longint      c;
        logic [63:0] d;
        logic [63:0] p;
        for (int k = 0; k < SIG_ENTRIES; k++)
        begin
            c = ((2 * longint'(k) + 1) * 524288) / SIG_ENTRIES - 524288;
            d = (64'd1 << 31) + exp_neg_fixed(64'(c < 0 ? -c : c));
            p = ((64'd1 << 47) + d / 2) / d;
            if (c < 0)
                p = 64'd65536 - p;
            if (p > 64'd65535)
                p = 64'd65535;
            prob_table[k] = p[PROB_W-1:0];
        end
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic res_t glauber_step(logic [2:0] cmd, int a, int b,
                                          logic signed [COUP_W-1:0] val,
                                          logic signed [1:0] sv, int rnd);
        res_t   r;
        int     n;
        bit     a_ok;
        longint h;
        longint x;
        longint off;
        longint k;
        longint e;
        int     prob;
        r    = '0;
        n    = active_setting > MAX_SPINS ? MAX_SPINS : active_setting;
        a_ok = a < n;
        h    = 0;
        e    = 0;
        prob = 0;
        if (cmd <= CMD_UPDATE && (!a_ok || (cmd == CMD_SET_COUPLING && b >= n)))
            r.status = 1'b1;
        else if (cmd == CMD_SET_SPIN)
        begin
            spin_shadow[a] = (sv == SPIN_LOW) ? SPIN_NEG : sv;
            cert_shadow[a] = CERT_RESET;
        end
        else if (cmd == CMD_SET_COUPLING)
        begin
            coup_shadow[a * MAX_SPINS + b] = val;
            coup_shadow[b * MAX_SPINS + a] = val;
        end
        else if (cmd == CMD_ADD_EVIDENCE)
            field_shadow[a] = FIELD_W'(clamp(longint'(field_shadow[a]) + longint'(val),
                                             FIELD_MIN, FIELD_MAX));
        else if (cmd == CMD_UPDATE)
        begin
            h = field_shadow[a];
            for (int j = 0; j < n; j++)
                if (j != a)
                    h += longint'(coup_shadow[a * MAX_SPINS + j]) * longint'(spin_shadow[j]);
            h    = clamp(h, FIELD_MIN, FIELD_MAX);
            x    = 2 * h * longint'(temp_setting);
            off  = clamp(x + 524288, 0, 1048576);
            k    = clamp((off * SIG_ENTRIES) / 1048576, 0, SIG_ENTRIES - 1);
            prob = prob_table[k];
            if (spin_shadow[a] == SPIN_NEG)
                spin_shadow[a] = (rnd < 65536 - prob) ? SPIN_NEG : SPIN_POS;
            else
                spin_shadow[a] = (rnd < prob) ? SPIN_POS : SPIN_NEG;
            if (cert_shadow[a] < CERT_MAX)
                cert_shadow[a] = cert_shadow[a] + 1'b1;
        end
        else if (cmd == CMD_READ_ENERGY)
        begin
            for (int i = 0; i < n; i++)
            begin
                e -= longint'(field_shadow[i]) * longint'(spin_shadow[i]);
                for (int j = i + 1; j < n; j++)
                    e -= longint'(coup_shadow[i * MAX_SPINS + j]) *
                         longint'(spin_shadow[i]) * longint'(spin_shadow[j]);
            end
            e = clamp(e, -64'sd2147483648, 64'sd2147483647);
        end
        r.local_field = h[FIELD_W-1:0];
        r.prob_up     = prob[PROB_W-1:0];
        r.energy      = e[ENERGY_W-1:0];
        if (!r.status && a_ok)
        begin
            r.new_spin  = spin_shadow[a];
            r.certainty = cert_shadow[a];
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_item(logic [2:0] cmd, int a, int b, int val, int sv, int rnd);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        push         <= 1'b1;
        command      <= cmd;
        index_a      <= IDX_W'(a);
        index_b      <= IDX_W'(b);
        value        <= COUP_W'(val);
        spin_value   <= 2'(sv);
        random_value <= RND_W'(rnd);
        do
            @(posedge clk);
        while (full);
        results_due.insert(results_due.size(),
                           glauber_step(cmd, a, b, COUP_W'(val), 2'(sv), rnd));
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ACTIVE_COUNT)
            active_setting = data & 8'h7F;
        else
            temp_setting = data & 16'hFFFF;
    endtask

    task automatic test_directed();
        send_item(CMD_READ_ENERGY, 0, 0, 0, 0, 0);
        send_item(CMD_UPDATE, 4, 0, 0, 0, 32768);
        send_item(CMD_SET_SPIN, 0, 0, 0, 1, 0);
        send_item(CMD_SET_SPIN, 1, 0, 0, -1, 0);
        send_item(CMD_SET_SPIN, 2, 0, 0, -2, 0);
        send_item(CMD_SET_SPIN, 3, 0, 0, 0, 0);
        send_item(CMD_SET_COUPLING, 0, 1, 32767, 0, 0);
        send_item(CMD_SET_COUPLING, 2, 1, -32768, 0, 0);
        send_item(CMD_SET_COUPLING, 5, 5, 100, 0, 0);
        send_item(CMD_ADD_EVIDENCE, 0, 0, 32767, 0, 0);
        send_item(CMD_ADD_EVIDENCE, 1, 0, -32768, 0, 0);
        send_item(CMD_UPDATE, 0, 0, 0, 0, 0);
        send_item(CMD_UPDATE, 1, 0, 0, 0, 65535);
        send_item(CMD_UPDATE, 2, 0, 0, 0, 12345);
        send_item(CMD_UPDATE, 5, 0, 0, 0, 40000);
        send_item(CMD_READ_ENERGY, 63, 0, 0, 0, 0);
        send_item(CMD_SPARE_FIRST, 1, 2, 7, 1, 3);
        send_item(CMD_SPARE_MID, 63, 63, -1, -1, 65535);
        send_item(CMD_SPARE_LAST, 0, 0, 0, 0, 0);
        write_reg(REG_ACTIVE_COUNT, 8);
        write_reg(REG_INV_TEMP, 65535);
        send_item(CMD_SET_SPIN, 8, 0, 0, 1, 0);
        send_item(CMD_SET_COUPLING, 0, 9, 55, 0, 0);
        send_item(CMD_UPDATE, 63, 0, 0, 0, 0);
        send_item(CMD_READ_ENERGY, 63, 0, 0, 0, 0);
        send_item(CMD_UPDATE, 0, 0, 0, 0, 30000);
        write_reg(REG_ACTIVE_COUNT, 0);
        send_item(CMD_UPDATE, 0, 0, 0, 0, 0);
        send_item(CMD_READ_ENERGY, 0, 0, 0, 0, 0);
        write_reg(REG_ACTIVE_COUNT, 64);
        write_reg(REG_INV_TEMP, 0);
        send_item(CMD_UPDATE, 1, 0, 0, 0, 32767);
        drain();
    endtask

    task automatic random_item();
        int n;
        int pick;
        int a;
        int b;
        int val;
        n    = active_setting > MAX_SPINS ? MAX_SPINS : active_setting;
        pick = $urandom_range(99);
        a    = (n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1) : $urandom_range(63);
        b    = (n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1) : $urandom_range(63);
        val  = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(2048) - 1024;
        if (pick < 15)
            send_item(CMD_SET_SPIN, a, b, val, $urandom_range(3), $urandom_range(65535));
        else if (pick < 35)
            send_item(CMD_SET_COUPLING, a, b, val, $urandom_range(3), $urandom_range(65535));
        else if (pick < 50)
            send_item(CMD_ADD_EVIDENCE, a, b, val, $urandom_range(3), $urandom_range(65535));
        else if (pick < 95 - (n > 16 ? 1 : 4))
            send_item(CMD_UPDATE, a, b, val, $urandom_range(3), $urandom_range(65535));
        else if (pick < 95)
            send_item(CMD_READ_ENERGY, a, b, val, $urandom_range(3), $urandom_range(65535));
        else
            send_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), a, b, val,
                      $urandom_range(3), $urandom_range(65535));
    endtask

    task automatic test_field_saturation();
        for (int i = 0; i < 270; i++)
            send_item(CMD_ADD_EVIDENCE, 3, 0, 32767, 0, 0);
        for (int i = 0; i < 6; i++)
            send_item(CMD_UPDATE, 3, 0, 0, 0, $urandom_range(65535));
        for (int i = 0; i < 270; i++)
            send_item(CMD_ADD_EVIDENCE, 9, 0, -32768, 0, 0);
        send_item(CMD_UPDATE, 9, 0, 0, 0, $urandom_range(65535));
        send_item(CMD_READ_ENERGY, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        steady   = 1'b1;
        for (int i = 0; i < 30; i++)
            send_item(CMD_SET_SPIN, $urandom_range(63), 0, 0, $urandom_range(3), 0);
        steady = 1'b0;
        drain();
    endtask

    task automatic test_random();
        int counts [5] = '{64, 8, 1, 127, 40};
        int temps [5]  = '{256, 65535, 0, 512, 1000};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_ACTIVE_COUNT, ($urandom_range(511) << 7) | counts[ph]);
            write_reg(REG_INV_TEMP, (ph == 4) ? $urandom_range(65535) : temps[ph]);
            steady = (ph == 1);
            for (int i = 0; i < 230; i++)
                random_item();
            steady = 1'b0;
        end
        drain();
    endtask

    // result side
    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && empty === 1'b0)
            begin
                if (results_due.size() == 0)
                begin
                    $display("unexpected result transaction at %0t", $time);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (new_spin !== want.new_spin)
                        report("new_spin", new_spin, want.new_spin);
                    if (local_field !== want.local_field)
                        report("local_field", local_field, want.local_field);
                    if (prob_up !== want.prob_up)
                        report("prob_up", prob_up, want.prob_up);
                    if (energy !== want.energy)
                        report("energy", energy, want.energy);
                    if (certainty !== want.certainty)
                        report("certainty", certainty, want.certainty);
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                pop <= 1'b0;
            end
            else if (steady)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #200000000;
        $display("[ising_glauber_spin_update] ERROR");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        command        = '0;
        index_a        = '0;
        index_b        = '0;
        value          = '0;
        spin_value     = '0;
        random_value   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pop            = 1'b0;
        error_count    = 0;
        steady         = 1'b0;
        hold_off       = 0;
        active_setting = 64;
        temp_setting   = 256;
        fill_prob_table();
        for (int i = 0; i < MAX_SPINS; i++)
        begin
            spin_shadow[i]  = SPIN_ZERO;
            field_shadow[i] = '0;
            cert_shadow[i]  = CERT_RESET;
        end
        for (int i = 0; i < COUP_DEPTH; i++)
            coup_shadow[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_field_saturation();
        test_random();
        repeat (20) @(posedge clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("[ising_glauber_spin_update] OK");
        else
            $display("[ising_glauber_spin_update] ERROR");
        $finish;
    end

endmodule
